[rtl/pdc_pkg.sv]
// pdc_pkg: shared types and codes for the page descriptor codec
// holds opcodes, block kinds, descriptor types, cache kinds and the result struct
// no dependencies
package pdc_pkg;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [1:0] LEVEL_FIRST = 2'd1;

  // block kinds
  localparam logic [2:0] KIND_INVALID  = 3'd0;
  localparam logic [2:0] KIND_BLOCK    = 3'd1;
  localparam logic [2:0] KIND_TABLE    = 3'd2;
  localparam logic [2:0] KIND_HIDDEN   = 3'd3;
  localparam logic [2:0] KIND_PHYSICAL = 3'd4;

  // descriptor types
  localparam logic [2:0] TYPE_PTABLE  = 3'd0;
  localparam logic [2:0] TYPE_SECTION = 3'd1;
  localparam logic [2:0] TYPE_SUPER   = 3'd2;
  localparam logic [2:0] TYPE_LARGE   = 3'd3;
  localparam logic [2:0] TYPE_SMALL   = 3'd4;
  localparam logic [2:0] TYPE_INVALID = 3'd5;

  // cache kinds
  localparam logic [1:0] CACHE_NC      = 2'd0;
  localparam logic [1:0] CACHE_WB      = 2'd1;
  localparam logic [1:0] CACHE_UNKNOWN = 2'd2;

  // permission bit positions
  localparam int P_PR = 0;
  localparam int P_PW = 1;
  localparam int P_PX = 2;
  localparam int P_UR = 3;
  localparam int P_UW = 4;
  localparam int P_UX = 5;

  localparam logic [31:0] DESC_HIDDEN   = 32'h0000_0004;
  localparam logic [31:0] DESC_PHYSICAL = 32'h0000_0008;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  level;
    logic [31:0] descriptor;
    logic [31:0] phys_addr;
    logic [5:0]  perms;
    logic [2:0]  block_kind;
    logic        is_global;
    logic        is_secure;
    logic [1:0]  cache_kind;
  } item_t;

  typedef struct packed {
    logic [31:0] descriptor;
    logic [31:0] phys_addr;
    logic [5:0]  perms;
    logic [2:0]  kind;
    logic        global_flag;
    logic        secure_flag;
    logic [1:0]  cache;
    logic [2:0]  type_code;
    logic        attr_error;
  } result_t;

endpackage

[rtl/page_descriptor_codec_top.sv]
// page_descriptor_codec_top: ARMv7 short-format descriptor encoder and decoder
// input register, one pass of packing logic, result register
// depends on pdc_pkg
//
// usage:
//   the input channel (in_valid/in_ready) takes one item per cycle while
//   in_ready is high: opcode 0 encodes level, block kind, permissions, flags
//   and cache kind into a descriptor word, opcode 1 decodes a descriptor into
//   type, aligned address and attributes. every item gives exactly one result
//   on the output channel (out_valid/out_ready), in order.
//   an accepted item goes to the input register, its result to the result
//   register that drives out_valid; throughput is one item per cycle while
//   out_ready is high, set by the single pass from input to result register.
//   the config channel (cfg_valid/cfg_ready/cfg_data) writes pxn_enable; it is
//   always ready and should be written only while the block is idle.
//   reset clears both pipeline valids and pxn_enable.
//   when the receiver stalls the result register holds and the input register
//   keeps accepting until it too is full; nothing is dropped.
module page_descriptor_codec_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [1:0]  level,
  input  logic [31:0] descriptor,
  input  logic [31:0] phys_addr,
  input  logic [5:0]  perms,
  input  logic [2:0]  block_kind,
  input  logic        is_global,
  input  logic        is_secure,
  input  logic [1:0]  cache_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_descriptor,
  output logic [31:0] out_phys_addr,
  output logic [5:0]  out_perms,
  output logic [2:0]  out_kind,
  output logic        out_global,
  output logic        out_secure,
  output logic [1:0]  out_cache,
  output logic [2:0]  out_type,
  output logic        attr_error
);

  logic              pxn_enable;
  logic              stage_valid;
  pdc_pkg::item_t    stage;
  logic              res_valid;
  pdc_pkg::result_t  res;
  pdc_pkg::result_t  res_next;
  logic              res_advance;

  assign cfg_ready   = 1'b1;
  assign res_advance = !res_valid || out_ready;
  assign in_ready    = !stage_valid || res_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pxn_enable <= 1'b0;
    end else if (cfg_valid) begin
      pxn_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (res_advance) begin
        res_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage.opcode     <= opcode;
      stage.level      <= level;
      stage.descriptor <= descriptor;
      stage.phys_addr  <= phys_addr;
      stage.perms      <= perms;
      stage.block_kind <= block_kind;
      stage.is_global  <= is_global;
      stage.is_secure  <= is_secure;
      stage.cache_kind <= cache_kind;
    end
    if (res_advance && stage_valid) begin
      res <= res_next;
    end
  end

  always_comb begin
    logic        first;
    logic [5:0]  a;
    logic [31:0] d;
    logic [31:0] enc;
    logic [2:0]  t;
    logic [2:0]  texcb;
    logic [31:0] mask;

    first    = (stage.level == pdc_pkg::LEVEL_FIRST);
    res_next = '0;
    d        = stage.descriptor;
    enc      = '0;
    t        = pdc_pkg::TYPE_INVALID;
    texcb    = '0;
    mask     = '0;

    // permission widening, order matters
    a = stage.perms;
    if (a[pdc_pkg::P_PX] || a[pdc_pkg::P_PW]) a[pdc_pkg::P_PR] = 1'b1;
    if (a[pdc_pkg::P_UX] || a[pdc_pkg::P_UW]) a[pdc_pkg::P_UR] = 1'b1;
    if (a[pdc_pkg::P_UR]) a[pdc_pkg::P_PR] = 1'b1;
    if (a[pdc_pkg::P_UW]) a[pdc_pkg::P_PW] = 1'b1;

    if (stage.opcode == pdc_pkg::OP_ENCODE) begin
      case (stage.block_kind)
        pdc_pkg::KIND_HIDDEN: begin
          enc = pdc_pkg::DESC_HIDDEN;
        end
        pdc_pkg::KIND_PHYSICAL: begin
          enc = pdc_pkg::DESC_PHYSICAL;
        end
        pdc_pkg::KIND_TABLE: begin
          if (first) begin
            enc    = stage.phys_addr;
            enc[0] = 1'b1;
            enc[3] = enc[3] | !stage.is_secure;
          end
        end
        pdc_pkg::KIND_BLOCK: begin
          if (stage.cache_kind > pdc_pkg::CACHE_WB) begin
            res_next.attr_error = 1'b1;
          end else begin
            if (first) begin
              enc[1]  = 1'b1;
              enc[16] = 1'b1;
              enc[4]  = !(a[pdc_pkg::P_PX] || a[pdc_pkg::P_UX]);
              enc[0]  = pxn_enable && !a[pdc_pkg::P_PX];
              enc[11] = a[pdc_pkg::P_UR];
              enc[15] = !a[pdc_pkg::P_PW];
              enc[10] = a[pdc_pkg::P_UR] || a[pdc_pkg::P_PR];
              enc[17] = !stage.is_global;
              enc[19] = !stage.is_secure;
            end else begin
              enc[1]  = 1'b1;
              enc[10] = 1'b1;
              enc[0]  = !(a[pdc_pkg::P_PX] || a[pdc_pkg::P_UX]);
              enc[5]  = a[pdc_pkg::P_UR];
              enc[9]  = !a[pdc_pkg::P_PW];
              enc[4]  = a[pdc_pkg::P_UR] || a[pdc_pkg::P_PR];
              enc[11] = !stage.is_global;
            end
            enc[2] = stage.cache_kind[0];
            enc    = enc | stage.phys_addr;
          end
        end
        default: begin
          enc = '0;
        end
      endcase
      res_next.descriptor = enc;
    end else begin
      // classify the descriptor
      if (d[1:0] == 2'b01) begin
        t = first ? pdc_pkg::TYPE_PTABLE : pdc_pkg::TYPE_LARGE;
      end else if (d[1]) begin
        if (!first) t = pdc_pkg::TYPE_SMALL;
        else        t = d[18] ? pdc_pkg::TYPE_SUPER : pdc_pkg::TYPE_SECTION;
      end

      case (t)
        pdc_pkg::TYPE_PTABLE:  mask = 32'hFFFF_FC00;
        pdc_pkg::TYPE_SECTION: mask = 32'hFFF0_0000;
        pdc_pkg::TYPE_SUPER:   mask = 32'hFF00_0000;
        pdc_pkg::TYPE_LARGE:   mask = 32'hFFFF_0000;
        pdc_pkg::TYPE_SMALL:   mask = 32'hFFFF_F000;
        default:               mask = 32'hFFFF_FFF0;
      endcase
      res_next.phys_addr = d & mask;
      res_next.type_code = t;

      if (t == pdc_pkg::TYPE_SECTION) begin
        res_next.perms[pdc_pkg::P_PR] = d[10];
        res_next.perms[pdc_pkg::P_UR] = d[10];
        res_next.perms[pdc_pkg::P_PX] = d[10] && !d[4] && !d[0];
        res_next.perms[pdc_pkg::P_UX] = d[10] && !d[4];
        res_next.perms[pdc_pkg::P_PW] = !d[15];
        res_next.perms[pdc_pkg::P_UW] = !d[15];
        res_next.kind        = pdc_pkg::KIND_BLOCK;
        res_next.global_flag = !d[17];
        res_next.secure_flag = !d[19];
        texcb = d[14:12] | {1'b0, d[3:2]};
      end else if (t == pdc_pkg::TYPE_SMALL) begin
        res_next.perms[pdc_pkg::P_PR] = d[4];
        res_next.perms[pdc_pkg::P_UR] = d[4];
        res_next.perms[pdc_pkg::P_PX] = d[4] && !d[0];
        res_next.perms[pdc_pkg::P_UX] = d[4] && !d[0];
        res_next.perms[pdc_pkg::P_PW] = !d[9];
        res_next.perms[pdc_pkg::P_UW] = !d[9];
        res_next.kind        = pdc_pkg::KIND_BLOCK;
        res_next.global_flag = !d[11];
        texcb = d[8:6] | {1'b0, d[3:2]};
      end else if (t == pdc_pkg::TYPE_INVALID) begin
        if (d[2])      res_next.kind = pdc_pkg::KIND_HIDDEN;
        else if (d[3]) res_next.kind = pdc_pkg::KIND_PHYSICAL;
      end

      // tex and cb are ored as written, not concatenated
      if (t == pdc_pkg::TYPE_SECTION || t == pdc_pkg::TYPE_SMALL) begin
        if (texcb == 3'd1)      res_next.cache = pdc_pkg::CACHE_WB;
        else if (texcb == 3'd0) res_next.cache = pdc_pkg::CACHE_NC;
        else                    res_next.cache = pdc_pkg::CACHE_UNKNOWN;
      end
    end
  end

  assign out_valid      = res_valid;
  assign out_descriptor = res.descriptor;
  assign out_phys_addr  = res.phys_addr;
  assign out_perms      = res.perms;
  assign out_kind       = res.kind;
  assign out_global     = res.global_flag;
  assign out_secure     = res.secure_flag;
  assign out_cache      = res.cache;
  assign out_type       = res.type_code;
  assign attr_error     = res.attr_error;

endmodule
